// File: rtl/buddy_block_allocator_defines.svh
// Assertion macros for the buddy block allocator.
// Used by rtl/buddy_block_allocator.sv; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/bba_pkg.sv
// Constants, types and helper functions of the buddy block allocator.
// No dependencies.
package bba_pkg;

   localparam int SPACE_LOG2     = 16;
   localparam int MIN_BLOCK_LOG2 = 4;
   localparam int HEADER_BYTES   = 8;

   localparam int LEVELS  = SPACE_LOG2 - MIN_BLOCK_LOG2 + 1;
   localparam int NODE_W  = LEVELS;
   localparam int NODES   = (1 << LEVELS) - 1;
   localparam int LEAF_W  = LEVELS - 1;
   localparam int LEAVES  = 1 << LEAF_W;
   localparam int LVL_W   = 4;
   localparam int ADDR_W  = 16;
   localparam int USED_W  = 17;

   localparam logic [NODE_W-1:0] NIL = NODE_W'(NODES);
   localparam logic              CMD_FREE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BIG  = 2'd1,
      ST_NONE = 2'd2,
      ST_BAD  = 2'd3
   } bba_status_type;

   function automatic logic [NODE_W-1:0] first_node(input logic [LVL_W-1:0] lv);
      first_node = (NODE_W'(1) << lv) - NODE_W'(1);
   endfunction

   function automatic logic [4:0] lvl_shift(input logic [LVL_W-1:0] lv);
      lvl_shift = 5'(SPACE_LOG2) - {1'b0, lv};
   endfunction

   function automatic logic [USED_W-1:0] blk_size(input logic [LVL_W-1:0] lv);
      blk_size = USED_W'(1) << lvl_shift(lv);
   endfunction

endpackage

// File: rtl/buddy_block_allocator.sv
// Buddy block allocator: sequencer over link, split-flag and level memories.
// Depends on bba_pkg and buddy_block_allocator_defines.svh.
//
// channel  ports                                   handshake
// request  req_command, req_request_bytes, req_address  start & !busy
// response rsp_status, rsp_block_address, rsp_used_bytes rsp_valid strobe
//
// A request rejected at entry is answered from idle; any other ends soonest
// on a bad free after the level lookup or on no free block at once. A flag
// toggle or list removal reads then writes, a list push writes node then
// head links, per tree level walked growing the root, splitting or merging.
// After reset a clearing pass over 4096 entries zeroes the split flags; busy
// is high meanwhile. The response strobe lasts one cycle and cannot stall.
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_address,
   output logic [16:0] rsp_used_bytes
);
   import bba_pkg::*;

   typedef enum logic [22:0] {
      S_CLEAR   = 23'b1 << 0,
      S_IDLE    = 23'b1 << 1,
      S_F_LVL   = 23'b1 << 2,
      S_F_LOOP  = 23'b1 << 3,
      S_F_AFT   = 23'b1 << 4,
      S_F_UP    = 23'b1 << 5,
      S_F_DONE  = 23'b1 << 6,
      S_G_CHK   = 23'b1 << 7,
      S_G_RD    = 23'b1 << 8,
      S_G_DEC   = 23'b1 << 9,
      S_G_F0    = 23'b1 << 10,
      S_G_F1    = 23'b1 << 11,
      S_A_POP   = 23'b1 << 12,
      S_A_TOP   = 23'b1 << 13,
      S_A_SPLIT = 23'b1 << 14,
      S_A_PUSH  = 23'b1 << 15,
      S_A_DONE  = 23'b1 << 16,
      S_FL_RD   = 23'b1 << 17,
      S_FL_WR   = 23'b1 << 18,
      S_RM_RD   = 23'b1 << 19,
      S_RM_WR   = 23'b1 << 20,
      S_PU_A    = 23'b1 << 21,
      S_PU_B    = 23'b1 << 22
   } bba_state_type;

   bba_state_type state_ff, state_in, ret_ff, ret_in;
   logic [LEAF_W-1:0] clr_ff, clr_in;
   logic [LVL_W-1:0]  root_ff, root_in, b_ff, b_in, orig_ff, orig_in;
   logic [LVL_W-1:0]  lva_ff, lva_in, tgt_ff, tgt_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              hvld_ff [LEVELS];
   logic              hvld_in [LEVELS];
   logic [NODE_W-1:0] hnd_ff [LEVELS];
   logic [NODE_W-1:0] hnd_in [LEVELS];
   logic [NODE_W-1:0] i_ff, i_in, nd_ff, nd_in;
   logic              retry_ff, retry_in, flag_ff, flag_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   logic [NODE_W-1:0] nxt_mem_ff [NODES];
   logic [NODE_W-1:0] prv_mem_ff [NODES];
   logic              flg_mem_ff [LEAVES];
   logic [LVL_W-1:0]  lvl_mem_ff [LEAVES];
   logic [NODE_W-1:0] nxt_rd_ff, prv_rd_ff;
   logic              flg_rd_ff;
   logic [LVL_W-1:0]  lvl_rd_ff;

   logic              nxt_we, prv_we, flg_we, lvl_we;
   logic [NODE_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic [LEAF_W-1:0] flg_wa, flg_ra, lvl_wa, lvl_ra;
   logic              flg_wd;
   logic [LVL_W-1:0]  lvl_wd;

   logic [USED_W-1:0] need;
   logic [LVL_W-1:0]  fit_lvl;
   logic [ADDR_W-1:0] req_off, alloc_off;
   logic              free_bad;
   logic [NODE_W-1:0] head_nd, nd_m1, buddy;
   logic              head_vld;
   logic [LEAF_W-1:0] nd_par;

   assign need     = USED_W'(req_request_bytes) + USED_W'(HEADER_BYTES);
   assign req_off  = req_address - ADDR_W'(HEADER_BYTES);
   assign free_bad = (req_address < ADDR_W'(HEADER_BYTES)) ||
                     (req_off[MIN_BLOCK_LOG2-1:0] != '0);
   assign head_vld = hvld_ff[lva_ff];
   assign head_nd  = hnd_ff[lva_ff];
   assign nd_m1    = nd_ff - NODE_W'(1);
   assign nd_par   = nd_m1[NODE_W-1:1];
   assign buddy    = ((i_ff - NODE_W'(1)) ^ NODE_W'(1)) + NODE_W'(1);
   assign alloc_off = ADDR_W'(i_ff - first_node(b_ff)) << lvl_shift(b_ff);
   assign flg_ra   = (state_ff == S_G_RD) ?
                     LEAF_W'(first_node(root_ff - LVL_W'(1))) : nd_par;
   assign lvl_ra   = req_off[ADDR_W-1:MIN_BLOCK_LOG2];

   always_comb begin
      fit_lvl = '0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (blk_size(LVL_W'(lv)) >= need) fit_lvl = LVL_W'(lv);
      end
   end

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;   clr_in = clr_ff;
      root_in  = root_ff;   b_in   = b_ff;     orig_in = orig_ff;
      lva_in   = lva_ff;    tgt_in = tgt_ff;   used_in = used_ff;
      hvld_in  = hvld_ff;   hnd_in = hnd_ff;   i_in = i_ff;  nd_in = nd_ff;
      retry_in = retry_ff;  flag_in = flag_ff; off_in = off_ff;
      rsp_valid_in = 1'b0;  rsp_status_in = rsp_status_ff;
      rsp_addr_in  = rsp_addr_ff;  rsp_used_in = rsp_used_ff;
      nxt_we = 1'b0;  nxt_wa = nd_ff;  nxt_wd = NIL;
      prv_we = 1'b0;  prv_wa = nd_ff;  prv_wd = NIL;
      flg_we = 1'b0;  flg_wa = nd_par; flg_wd = 1'b0;
      lvl_we = 1'b0;  lvl_wa = off_ff[ADDR_W-1:MIN_BLOCK_LOG2];
      lvl_wd = LVL_W'(LEVELS);
      unique case (state_ff)
         S_CLEAR: begin
            flg_we = 1'b1;
            flg_wa = clr_ff;
            if (clr_ff == '0) begin
               nxt_we = 1'b1;
               nxt_wa = first_node(LVL_W'(LEVELS - 1));
               prv_we = 1'b1;
               prv_wa = first_node(LVL_W'(LEVELS - 1));
            end
            clr_in = clr_ff + LEAF_W'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_command == CMD_FREE) begin
                  if (free_bad) begin
                     rsp_valid_in = 1'b1;  rsp_status_in = ST_BAD;
                     rsp_addr_in = '0;     rsp_used_in = used_ff;
                  end else begin
                     off_in = req_off;
                     state_in = S_F_LVL;
                  end
               end else if (need > (USED_W'(1) << SPACE_LOG2)) begin
                  rsp_valid_in = 1'b1;  rsp_status_in = ST_BIG;
                  rsp_addr_in = '0;     rsp_used_in = used_ff;
               end else begin
                  orig_in = fit_lvl;  b_in = fit_lvl;  tgt_in = fit_lvl;
                  retry_in = 1'b0;
                  state_in = S_G_CHK;
               end
            end
         end
         S_F_LVL: begin
            if ((lvl_rd_ff >= LVL_W'(LEVELS)) || (lvl_rd_ff < root_ff) ||
                ((USED_W'(off_ff) & (blk_size(lvl_rd_ff) - USED_W'(1))) != '0)) begin
               rsp_valid_in = 1'b1;  rsp_status_in = ST_BAD;
               rsp_addr_in = '0;     rsp_used_in = used_ff;
               state_in = S_IDLE;
            end else begin
               b_in = lvl_rd_ff;
               used_in = used_ff - blk_size(lvl_rd_ff);
               lvl_we = 1'b1;
               i_in = NODE_W'(off_ff >> lvl_shift(lvl_rd_ff)) + first_node(lvl_rd_ff);
               state_in = S_F_LOOP;
            end
         end
         S_F_LOOP: begin
            nd_in = i_ff;
            lva_in = b_ff;
            if (i_ff == '0) begin
               state_in = S_PU_A;  ret_in = S_F_DONE;
            end else begin
               state_in = S_FL_RD; ret_in = S_F_AFT;
            end
         end
         S_F_AFT: begin
            lva_in = b_ff;
            if (flag_ff || (b_ff == root_ff)) begin
               nd_in = i_ff;
               state_in = S_PU_A;  ret_in = S_F_DONE;
            end else begin
               nd_in = buddy;
               state_in = S_RM_RD; ret_in = S_F_UP;
            end
         end
         S_F_UP: begin
            i_in = (i_ff - NODE_W'(1)) >> 1;
            b_in = b_ff - LVL_W'(1);
            state_in = S_F_LOOP;
         end
         S_F_DONE: begin
            rsp_valid_in = 1'b1;  rsp_status_in = ST_OK;
            rsp_addr_in = '0;     rsp_used_in = used_ff;
            state_in = S_IDLE;
         end
         S_G_CHK: begin
            if (tgt_ff < root_ff) begin
               state_in = S_G_RD;
            end else begin
               lva_in = b_ff;
               state_in = S_A_POP;
            end
         end
         S_G_RD: state_in = S_G_DEC;
         S_G_DEC: begin
            lva_in = root_ff;
            if (!flg_rd_ff) begin
               nd_in = first_node(root_ff);
               state_in = S_RM_RD;  ret_in = S_G_F0;
            end else begin
               nd_in = first_node(root_ff) + NODE_W'(1);
               state_in = S_PU_A;   ret_in = S_G_F1;
            end
         end
         S_G_F0: begin
            root_in = root_ff - LVL_W'(1);
            hvld_in[root_ff - LVL_W'(1)] = 1'b0;
            lva_in = root_ff - LVL_W'(1);
            nd_in = first_node(root_ff - LVL_W'(1));
            state_in = S_PU_A;  ret_in = S_G_CHK;
         end
         S_G_F1: begin
            root_in = root_ff - LVL_W'(1);
            hvld_in[root_ff - LVL_W'(1)] = 1'b0;
            nd_in = first_node(root_ff - LVL_W'(1));
            if (first_node(root_ff - LVL_W'(1)) != '0) begin
               state_in = S_FL_RD;  ret_in = S_G_CHK;
            end else begin
               state_in = S_G_CHK;
            end
         end
         S_A_POP: begin
            if (head_vld) begin
               i_in = head_nd;  nd_in = head_nd;
               state_in = S_RM_RD;  ret_in = S_A_TOP;
            end else if (retry_ff || (b_ff == '0)) begin
               rsp_valid_in = 1'b1;  rsp_status_in = ST_NONE;
               rsp_addr_in = '0;     rsp_used_in = used_ff;
               state_in = S_IDLE;
            end else if (b_ff != root_ff) begin
               b_in = b_ff - LVL_W'(1);
               tgt_in = b_ff - LVL_W'(1);
               state_in = S_G_CHK;
            end else begin
               retry_in = 1'b1;
               tgt_in = b_ff - LVL_W'(1);
               state_in = S_G_CHK;
            end
         end
         S_A_TOP: begin
            nd_in = i_ff;
            if (i_ff != '0) begin
               state_in = S_FL_RD;  ret_in = S_A_SPLIT;
            end else begin
               state_in = S_A_SPLIT;
            end
         end
         S_A_SPLIT: begin
            if (b_ff < orig_ff) begin
               i_in = {i_ff[NODE_W-2:0], 1'b1};
               nd_in = {i_ff[NODE_W-2:0], 1'b1};
               b_in = b_ff + LVL_W'(1);
               state_in = S_FL_RD;  ret_in = S_A_PUSH;
            end else begin
               state_in = S_A_DONE;
            end
         end
         S_A_PUSH: begin
            nd_in = i_ff + NODE_W'(1);
            lva_in = b_ff;
            state_in = S_PU_A;  ret_in = S_A_SPLIT;
         end
         S_A_DONE: begin
            lvl_we = 1'b1;
            lvl_wa = alloc_off[ADDR_W-1:MIN_BLOCK_LOG2];
            lvl_wd = b_ff;
            used_in = used_ff + blk_size(b_ff);
            rsp_valid_in = 1'b1;  rsp_status_in = ST_OK;
            rsp_addr_in = alloc_off + ADDR_W'(HEADER_BYTES);
            rsp_used_in = used_ff + blk_size(b_ff);
            state_in = S_IDLE;
         end
         S_FL_RD: state_in = S_FL_WR;
         S_FL_WR: begin
            flg_we = 1'b1;
            flg_wd = ~flg_rd_ff;
            flag_in = ~flg_rd_ff;
            state_in = ret_ff;
         end
         S_RM_RD: state_in = S_RM_WR;
         S_RM_WR: begin
            if (prv_rd_ff != NIL) begin
               nxt_we = 1'b1;  nxt_wa = prv_rd_ff;  nxt_wd = nxt_rd_ff;
            end else if (head_vld && (head_nd == nd_ff)) begin
               hvld_in[lva_ff] = (nxt_rd_ff != NIL);
               hnd_in[lva_ff] = nxt_rd_ff;
            end
            if (nxt_rd_ff != NIL) begin
               prv_we = 1'b1;  prv_wa = nxt_rd_ff;  prv_wd = prv_rd_ff;
            end
            state_in = ret_ff;
         end
         S_PU_A: begin
            nxt_we = 1'b1;
            nxt_wd = head_vld ? head_nd : NIL;
            prv_we = 1'b1;
            state_in = S_PU_B;
         end
         S_PU_B: begin
            if (head_vld) begin
               prv_we = 1'b1;  prv_wa = head_nd;  prv_wd = nd_ff;
            end
            hvld_in[lva_ff] = 1'b1;
            hnd_in[lva_ff] = nd_ff;
            state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         root_ff <= LVL_W'(LEVELS - 1);
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int lv = 0; lv < LEVELS; lv++) begin
            hvld_ff[lv] <= (lv == LEVELS - 1);
            hnd_ff[lv] <= first_node(LVL_W'(LEVELS - 1));
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         root_ff <= root_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         hvld_ff <= hvld_in;
         hnd_ff <= hnd_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;      b_ff <= b_in;        orig_ff <= orig_in;
      lva_ff <= lva_in;      tgt_ff <= tgt_in;    i_ff <= i_in;
      nd_ff <= nd_in;        retry_ff <= retry_in; flag_ff <= flag_in;
      off_ff <= off_in;      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;  rsp_used_ff <= rsp_used_in;
   end

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem_ff[nxt_wa] <= nxt_wd;
      nxt_rd_ff <= nxt_mem_ff[nd_ff];
   end

   always_ff @(posedge clock) begin
      if (prv_we) prv_mem_ff[prv_wa] <= prv_wd;
      prv_rd_ff <= prv_mem_ff[nd_ff];
   end

   always_ff @(posedge clock) begin
      if (flg_we) flg_mem_ff[flg_wa] <= flg_wd;
      flg_rd_ff <= flg_mem_ff[flg_ra];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem_ff[lvl_wa] <= lvl_wd;
      lvl_rd_ff <= lvl_mem_ff[lvl_ra];
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_used_bytes    = rsp_used_ff;

   `BBA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `BBA_ASSERT_NEXT(a_accept_acts, clock, reset, start && !busy, rsp_valid || busy)
   `BBA_ASSERT_SAME(a_root_range, clock, reset, 1'b1, root_ff <= LVL_W'(LEVELS - 1))
   `BBA_ASSERT_SAME(a_used_range, clock, reset, 1'b1, used_ff <= (USED_W'(1) << SPACE_LOG2))

endmodule
